// File: hw/rtl/ldyp_pkg.sv
package ldyp_pkg;

   localparam int COORD_BITS    = 20;
   localparam int CORDIC_STAGES = 16;
   localparam int GUARD_BITS    = 12;
   localparam int ATAN_LEN      = 24;

   // difference of two coordinates
   localparam int DW = COORD_BITS + 1;
   // CORDIC datapath: scaled difference plus room for the gain of both passes
   localparam int CW = COORD_BITS + GUARD_BITS + 5;
   // angle accumulator, degrees with 16 fraction bits
   localparam int AW = 26;
   // final rounding and clamping
   localparam int RW = AW + 2;
   localparam int SHIFT_BITS = $clog2(ATAN_LEN);

   localparam int YAW_W   = 18;
   localparam int PITCH_W = 16;

   localparam int GAIN_W     = 17;
   localparam int GAIN_SHIFT = 15;
   localparam int GAIN_DROP  = GAIN_SHIFT - GUARD_BITS;
   localparam logic signed [GAIN_W-1:0] GAIN_Q15 = GAIN_W'(53961);

   localparam logic signed [AW-1:0] DEG90_Q16 = AW'(90 * 65536);

   localparam logic signed [RW-1:0] YAW_MIN   = RW'(-69120);
   localparam logic signed [RW-1:0] YAW_MAX   = RW'(23040);
   localparam logic signed [RW-1:0] PITCH_MIN = RW'(-23040);
   localparam logic signed [RW-1:0] PITCH_MAX = RW'(23040);
   localparam logic signed [RW-1:0] ROUND_HALF = RW'(128);

   // atan(2^-i) in degrees, 16 fraction bits
   localparam logic signed [AW-1:0] ATAN_TAB [ATAN_LEN] = '{
      AW'(2949120), AW'(1740967), AW'(919879), AW'(466945),
      AW'(234379),  AW'(117304),  AW'(58666),  AW'(29335),
      AW'(14668),   AW'(7334),    AW'(3667),   AW'(1833),
      AW'(917),     AW'(458),     AW'(229),    AW'(115),
      AW'(57),      AW'(29),      AW'(14),     AW'(7),
      AW'(4),       AW'(2),       AW'(1),      AW'(0)
   };

   typedef struct packed {
      logic                 valid;
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] aux;
   } pre_in_type;

   typedef struct packed {
      logic                 valid;
      logic                 zero;
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [AW-1:0] acc;
      logic signed [CW-1:0] aux;
   } cell_type;

endpackage

// File: hw/rtl/ldyp_pre.sv
// Quadrant fold ahead of a CORDIC chain: brings x onto the non-negative half plane.
module ldyp_pre (
   input  logic                 clock,
   input  logic                 reset,
   input  ldyp_pkg::pre_in_type pre_in,
   output ldyp_pkg::cell_type   pre_out
);

   ldyp_pkg::cell_type state_ff;
   ldyp_pkg::cell_type state_in;

   always_comb begin
      state_in       = '0;
      state_in.valid = pre_in.valid;
      state_in.zero  = (pre_in.x == '0) && (pre_in.y == '0);
      state_in.aux   = pre_in.aux;
      state_in.x     = pre_in.x;
      state_in.y     = pre_in.y;
      state_in.acc   = '0;
      if (pre_in.x < 0) begin
         if (pre_in.y >= 0) begin
            state_in.x   = pre_in.y;
            state_in.y   = -pre_in.x;
            state_in.acc = ldyp_pkg::DEG90_Q16;
         end else begin
            state_in.x   = -pre_in.y;
            state_in.y   = pre_in.x;
            state_in.acc = -ldyp_pkg::DEG90_Q16;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.valid <= 1'b0;
      end else begin
         state_ff.valid <= state_in.valid;
      end
      state_ff.zero <= state_in.zero;
      state_ff.x    <= state_in.x;
      state_ff.y    <= state_in.y;
      state_ff.acc  <= state_in.acc;
      state_ff.aux  <= state_in.aux;
   end

   assign pre_out = state_ff;

endmodule

// File: hw/rtl/ldyp_cell.sv
// One vectoring micro-rotation; shifts floor towards minus infinity.
module ldyp_cell (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [ldyp_pkg::SHIFT_BITS-1:0]       shift_amt,
   input  logic signed [ldyp_pkg::AW-1:0]        atan_step,
   input  ldyp_pkg::cell_type                    cell_in,
   output ldyp_pkg::cell_type                    cell_out
);

   ldyp_pkg::cell_type          state_ff;
   ldyp_pkg::cell_type          state_in;
   logic signed [ldyp_pkg::CW-1:0] xs;
   logic signed [ldyp_pkg::CW-1:0] ys;

   always_comb begin
      xs       = cell_in.x >>> shift_amt;
      ys       = cell_in.y >>> shift_amt;
      state_in = cell_in;
      if (cell_in.y >= 0) begin
         state_in.x   = cell_in.x + ys;
         state_in.y   = cell_in.y - xs;
         state_in.acc = cell_in.acc + atan_step;
      end else begin
         state_in.x   = cell_in.x - ys;
         state_in.y   = cell_in.y + xs;
         state_in.acc = cell_in.acc - atan_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.valid <= 1'b0;
      end else begin
         state_ff.valid <= state_in.valid;
      end
      state_ff.zero <= state_in.zero;
      state_ff.x    <= state_in.x;
      state_ff.y    <= state_in.y;
      state_ff.acc  <= state_in.acc;
      state_ff.aux  <= state_in.aux;
   end

   assign cell_out = state_ff;

endmodule

// File: hw/rtl/look_direction_yaw_pitch.sv
// Viewing angles from a camera position and a look-at point.
//
// Input: raise start with the six coordinates (signed, 8 fraction bits) on the
// req_ ports; the word is taken at any edge where start is high and busy is low.
// busy stays low, so a new word may enter on every cycle.
// Output: rsp_valid is high for exactly one cycle with rsp_yaw_angle and
// rsp_pitch_angle, both in 1/256 degree. The receiver cannot stall the block;
// results appear in the order the words were taken.
// The pipeline registers the differences, then the quadrant fold and gain
// multiply, then runs one chain of cells for yaw and horizontal distance, a
// second fold, a second chain for pitch and finally the rounding and
// clamping. Throughput is one word per cycle, set by the fully unrolled cell
// chains.
// Synchronous reset empties the pipeline: words in flight are dropped and no
// strobe is given for them.
module look_direction_yaw_pitch (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       start,
   output logic                                       busy,
   input  logic signed [ldyp_pkg::COORD_BITS-1:0]     req_cam_x,
   input  logic signed [ldyp_pkg::COORD_BITS-1:0]     req_cam_y,
   input  logic signed [ldyp_pkg::COORD_BITS-1:0]     req_cam_z,
   input  logic signed [ldyp_pkg::COORD_BITS-1:0]     req_target_x,
   input  logic signed [ldyp_pkg::COORD_BITS-1:0]     req_target_y,
   input  logic signed [ldyp_pkg::COORD_BITS-1:0]     req_target_z,
   output logic                                       rsp_valid,
   output logic signed [ldyp_pkg::YAW_W-1:0]          rsp_yaw_angle,
   output logic signed [ldyp_pkg::PITCH_W-1:0]        rsp_pitch_angle
);

   localparam int DW = ldyp_pkg::DW;
   localparam int CW = ldyp_pkg::CW;
   localparam int AW = ldyp_pkg::AW;
   localparam int RW = ldyp_pkg::RW;
   localparam int NS = ldyp_pkg::CORDIC_STAGES;
   localparam int PW = DW + ldyp_pkg::GAIN_W;

   logic                 diff_valid_ff;
   logic signed [DW-1:0] diff_x_ff, diff_y_ff, diff_z_ff;
   logic signed [PW-1:0] gain_prod;

   ldyp_pkg::pre_in_type pre1_in, pre2_in;
   ldyp_pkg::cell_type   pass1 [NS+1];
   ldyp_pkg::cell_type   pass2 [NS+1];

   logic signed [RW-1:0] yaw_q, pitch_q, yaw_r, pitch_r;
   logic signed [RW-1:0] yaw_in, pitch_in;
   logic signed [AW-1:0] a1, a2;

   logic                          rsp_valid_ff;
   logic signed [ldyp_pkg::YAW_W-1:0]   yaw_ff;
   logic signed [ldyp_pkg::PITCH_W-1:0] pitch_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         diff_valid_ff <= 1'b0;
      end else begin
         diff_valid_ff <= start & ~busy;
      end
      diff_x_ff <= DW'(req_cam_x) - DW'(req_target_x);
      diff_y_ff <= DW'(req_cam_y) - DW'(req_target_y);
      diff_z_ff <= DW'(req_cam_z) - DW'(req_target_z);
   end

   // dz scaled by the CORDIC gain; guard shift and gain shift folded together
   assign gain_prod = PW'(diff_z_ff) * PW'(ldyp_pkg::GAIN_Q15);

   always_comb begin
      pre1_in.valid = diff_valid_ff;
      pre1_in.y     = CW'(diff_x_ff) <<< ldyp_pkg::GUARD_BITS;
      pre1_in.x     = CW'(diff_y_ff) <<< ldyp_pkg::GUARD_BITS;
      pre1_in.aux   = CW'(gain_prod >>> ldyp_pkg::GAIN_DROP);
   end

   ldyp_pre u_pre1 (
      .clock   (clock),
      .reset   (reset),
      .pre_in  (pre1_in),
      .pre_out (pass1[0])
   );

   for (genvar i = 0; i < NS; i++) begin : g_pass1
      ldyp_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift_amt (ldyp_pkg::SHIFT_BITS'(i)),
         .atan_step (ldyp_pkg::ATAN_TAB[i]),
         .cell_in   (pass1[i]),
         .cell_out  (pass1[i+1])
      );
   end

   // second pass: y is the horizontal distance, x the gain-scaled dz; yaw rides along
   always_comb begin
      pre2_in.valid = pass1[NS].valid;
      pre2_in.y     = pass1[NS].x;
      pre2_in.x     = pass1[NS].aux;
      pre2_in.aux   = pass1[NS].zero ? '0 : CW'(pass1[NS].acc);
   end

   ldyp_pre u_pre2 (
      .clock   (clock),
      .reset   (reset),
      .pre_in  (pre2_in),
      .pre_out (pass2[0])
   );

   for (genvar i = 0; i < NS; i++) begin : g_pass2
      ldyp_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift_amt (ldyp_pkg::SHIFT_BITS'(i)),
         .atan_step (ldyp_pkg::ATAN_TAB[i]),
         .cell_in   (pass2[i]),
         .cell_out  (pass2[i+1])
      );
   end

   always_comb begin
      a1      = AW'(pass2[NS].aux);
      a2      = pass2[NS].zero ? '0 : pass2[NS].acc;
      yaw_q   = -RW'(a1) - RW'(ldyp_pkg::DEG90_Q16);
      pitch_q = RW'(ldyp_pkg::DEG90_Q16) - RW'(a2);
      yaw_r   = (yaw_q + ldyp_pkg::ROUND_HALF) >>> 8;
      pitch_r = (pitch_q + ldyp_pkg::ROUND_HALF) >>> 8;
      priority if (yaw_r < ldyp_pkg::YAW_MIN) begin
         yaw_in = ldyp_pkg::YAW_MIN;
      end else if (yaw_r > ldyp_pkg::YAW_MAX) begin
         yaw_in = ldyp_pkg::YAW_MAX;
      end else begin
         yaw_in = yaw_r;
      end
      priority if (pitch_r < ldyp_pkg::PITCH_MIN) begin
         pitch_in = ldyp_pkg::PITCH_MIN;
      end else if (pitch_r > ldyp_pkg::PITCH_MAX) begin
         pitch_in = ldyp_pkg::PITCH_MAX;
      end else begin
         pitch_in = pitch_r;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= pass2[NS].valid;
      end
      yaw_ff   <= yaw_in[ldyp_pkg::YAW_W-1:0];
      pitch_ff <= pitch_in[ldyp_pkg::PITCH_W-1:0];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_yaw_angle   = yaw_ff;
   assign rsp_pitch_angle = pitch_ff;

   a_pass_handoff : assert property (@(posedge clock) disable iff (reset)
      pass1[NS].valid |=> pass2[0].valid)
      else $error("word lost between the two CORDIC chains");

   a_zero_yaw : assert property (@(posedge clock) disable iff (reset)
      (pass2[0].valid && pass2[0].zero) |-> (pass2[0].aux == '0))
      else $error("zero difference vector with non-zero yaw");

   a_yaw_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (RW'(rsp_yaw_angle) >= ldyp_pkg::YAW_MIN
                     && RW'(rsp_yaw_angle) <= ldyp_pkg::YAW_MAX))
      else $error("yaw outside its range");

   a_pitch_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (RW'(rsp_pitch_angle) >= ldyp_pkg::PITCH_MIN
                     && RW'(rsp_pitch_angle) <= ldyp_pkg::PITCH_MAX))
      else $error("pitch outside its range");

endmodule

// File: sim/look_direction_yaw_pitch_tb.sv
`timescale 1ns / 1ps

module look_direction_yaw_pitch_tb;

   localparam int CB        = ldyp_pkg::COORD_BITS;
   localparam int YW        = ldyp_pkg::YAW_W;
   localparam int PW        = ldyp_pkg::PITCH_W;
   localparam int STAGES    = ldyp_pkg::CORDIC_STAGES;
   localparam int WORDS     = 1200;
   localparam int DRAIN     = 2 * STAGES + 12;
   localparam int CYCLE_LIMIT = 200000;

   typedef logic signed [CB-1:0] coord_type;
   typedef logic signed [YW-1:0] yaw_type;
   typedef logic signed [PW-1:0] pitch_type;

   typedef struct {
      yaw_type   yaw;
      pitch_type pitch;
   } angle_pair_type;

   localparam coord_type CMAX = coord_type'((1 << (CB - 1)) - 1);
   localparam coord_type CMIN = coord_type'(-(1 << (CB - 1)));

   class view_angle_board;
      // atan(2^-i) in degrees, 16 fraction bits
      localparam longint ARC_STEP [24] = '{
         2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
         14668, 7334, 3667, 1833, 917, 458, 229, 115,
         57, 29, 14, 7, 4, 2, 1, 0
      };
      localparam longint RIGHT_ANGLE = 90 * 65536;
      localparam longint DZ_GAIN     = 53961;

      angle_pair_type pending_angles[$];
      int             mismatches = 0;

      // angle of (x, y) in Q16 degrees, four quadrants; mag gets the scaled length
      function longint vector_angle(longint y, longint x, output longint mag);
         longint acc;
         longint t;
         longint xs;
         longint ys;
         acc = 0;
         if (x == 0 && y == 0) begin
            mag = 0;
            return 0;
         end
         if (x < 0) begin
            if (y >= 0) begin
               t = x; x = y; y = -t; acc = RIGHT_ANGLE;
            end else begin
               t = x; x = -y; y = t; acc = -RIGHT_ANGLE;
            end
         end
         for (int i = 0; i < STAGES && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
               x = x + ys; y = y - xs; acc += ARC_STEP[i];
            end else begin
               x = x - ys; y = y + xs; acc -= ARC_STEP[i];
            end
         end
         mag = x;
         return acc;
      endfunction

      function longint round_to_bounds(longint q16, longint lo, longint hi);
         longint r;
         r = (q16 + 128) >>> 8;
         if (r < lo) r = lo;
         if (r > hi) r = hi;
         return r;
      endfunction

      function void note_word(coord_type cx, coord_type cy, coord_type cz,
                              coord_type tx, coord_type ty, coord_type tz);
         longint dx;
         longint dy;
         longint dz;
         longint flat_len;
         longint spare;
         longint a1;
         longint a2;
         longint r;
         angle_pair_type p;
         dx = (longint'(cx) - longint'(tx)) * 4096;
         dy = (longint'(cy) - longint'(ty)) * 4096;
         dz = (longint'(cz) - longint'(tz)) * 4096;
         a1 = vector_angle(dx, dy, flat_len);
         dz = (dz * DZ_GAIN) >>> 15;
         a2 = vector_angle(flat_len, dz, spare);
         r = round_to_bounds(-a1 - RIGHT_ANGLE, -69120, 23040);
         p.yaw = r[YW-1:0];
         r = round_to_bounds(RIGHT_ANGLE - a2, -23040, 23040);
         p.pitch = r[PW-1:0];
         pending_angles.push_back(p);
      endfunction

      function void check_result(yaw_type yaw, pitch_type pitch);
         angle_pair_type p;
         if (pending_angles.size() == 0) begin
            if (mismatches < 10)
               $display("unexpected result: yaw %0d pitch %0d", yaw, pitch);
            mismatches++;
            return;
         end
         p = pending_angles.pop_front();
         if (p.yaw !== yaw || p.pitch !== pitch) begin
            if (mismatches < 10)
               $display("angle mismatch: expected yaw %0d pitch %0d, got yaw %0d pitch %0d",
                        p.yaw, p.pitch, yaw, pitch);
            mismatches++;
         end
      endfunction

      function int outstanding();
         return pending_angles.size();
      endfunction
   endclass

   logic      clock;
   logic      reset = 1'b1;
   logic      start = 1'b0;
   logic      busy;
   coord_type req_cam_x = '0;
   coord_type req_cam_y = '0;
   coord_type req_cam_z = '0;
   coord_type req_target_x = '0;
   coord_type req_target_y = '0;
   coord_type req_target_z = '0;
   logic      rsp_valid;
   yaw_type   rsp_yaw_angle;
   pitch_type rsp_pitch_angle;

   view_angle_board board = new;
   int cycle_count = 0;

   look_direction_yaw_pitch dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cam_x       (req_cam_x),
      .req_cam_y       (req_cam_y),
      .req_cam_z       (req_cam_z),
      .req_target_x    (req_target_x),
      .req_target_y    (req_target_y),
      .req_target_z    (req_target_z),
      .rsp_valid       (rsp_valid),
      .rsp_yaw_angle   (rsp_yaw_angle),
      .rsp_pitch_angle (rsp_pitch_angle)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // words taken and results seen, both sampled at the edge
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            board.note_word(req_cam_x, req_cam_y, req_cam_z,
                            req_target_x, req_target_y, req_target_z);
         if (rsp_valid)
            board.check_result(rsp_yaw_angle, rsp_pitch_angle);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic send_word(coord_type cx, coord_type cy, coord_type cz,
                            coord_type tx, coord_type ty, coord_type tz);
      start        <= 1'b1;
      req_cam_x    <= cx;
      req_cam_y    <= cy;
      req_cam_z    <= cz;
      req_target_x <= tx;
      req_target_y <= ty;
      req_target_z <= tz;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // gap with junk on the req_ ports; the block must ignore it
   task automatic pause_sender(int n);
      if (n > 0) begin
         start        <= 1'b0;
         req_cam_x    <= coord_type'($urandom);
         req_cam_y    <= coord_type'($urandom);
         req_cam_z    <= coord_type'($urandom);
         req_target_x <= coord_type'($urandom);
         req_target_y <= coord_type'($urandom);
         req_target_z <= coord_type'($urandom);
         repeat (n) @(posedge clock);
      end
   endtask

   function automatic coord_type pick_coord(int mode);
      int k;
      case (mode)
         0: begin
            case ($urandom_range(0, 4))
               0: return CMAX;
               1: return CMIN;
               2: return '0;
               3: return coord_type'(-1);
               default: return coord_type'(1);
            endcase
         end
         1: begin
            k = $urandom_range(0, CB - 2);
            return coord_type'(longint'($urandom_range(0, 2 << k)) - (longint'(1) << k));
         end
         default: return coord_type'($urandom);
      endcase
   endfunction

   task automatic send_random_word();
      coord_type c [3];
      coord_type t [3];
      int        mode;
      int        k;
      mode = $urandom_range(0, 9);
      for (int a = 0; a < 3; a++) begin
         if (mode <= 2) begin
            c[a] = pick_coord(2);
            t[a] = pick_coord(2);
         end else if (mode <= 4) begin
            // close pair: small differences of mixed size
            k = $urandom_range(0, 12);
            t[a] = pick_coord(2);
            c[a] = t[a]
                   + coord_type'(longint'($urandom_range(0, 2 << k)) - (longint'(1) << k));
         end else if (mode == 5) begin
            // some axes with no difference at all
            t[a] = pick_coord($urandom_range(0, 2));
            c[a] = ($urandom_range(0, 1) != 0) ? t[a] : pick_coord($urandom_range(0, 2));
         end else if (mode == 6) begin
            c[a] = pick_coord(0);
            t[a] = pick_coord(0);
         end else begin
            c[a] = pick_coord(1);
            t[a] = pick_coord(1);
         end
      end
      send_word(c[0], c[1], c[2], t[0], t[1], t[2]);
   endtask

   initial begin
      int sent;
      int burst;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // zero vector, then each horizontal axis direction
      send_word('0, '0, '0, '0, '0, '0);
      send_word('0, coord_type'(256), '0, '0, '0, '0);
      send_word('0, coord_type'(-256), '0, '0, '0, '0);
      send_word(coord_type'(256), '0, '0, '0, '0, '0);
      send_word(coord_type'(-256), '0, '0, '0, '0, '0);
      pause_sender(3);
      // vertical only: straight up and the negative axis of the second pass
      send_word('0, '0, coord_type'(512), '0, '0, '0);
      send_word('0, '0, coord_type'(-512), '0, '0, '0);
      // largest differences both ways, then zero differences at the extremes
      send_word(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN);
      send_word(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
      send_word(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
      send_word(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN);
      pause_sender(1);
      // yaw at the edges of its range, where the residual can overshoot
      send_word(coord_type'(-1), CMIN, '0, '0, CMAX, '0);
      send_word(coord_type'(1), CMIN, '0, '0, CMAX, '0);
      send_word(coord_type'(-1), coord_type'(-1), '0, '0, '0, '0);
      send_word(coord_type'(1), coord_type'(-1), '0, '0, '0, '0);
      // pitch near its bounds: tiny horizontal, huge vertical; then huge horizontal with small or huge vertical
      send_word(coord_type'(1), '0, CMAX, '0, '0, CMIN);
      send_word(coord_type'(1), '0, CMIN, '0, '0, CMAX);
      send_word(CMAX, CMIN, coord_type'(1), CMIN, CMAX, '0);
      send_word(CMIN, CMAX, coord_type'(-1), CMAX, CMIN, '0);
      send_word(CMAX, '0, CMIN, '0, '0, '0);
      pause_sender(2);

      sent = 0;
      while (sent < WORDS) begin
         burst = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 20);
         for (int b = 0; b < burst && sent < WORDS; b++) begin
            send_random_word();
            sent++;
         end
         if ($urandom_range(0, 3) != 0)
            pause_sender($urandom_range(1, 10));
      end
      start <= 1'b0;

      while (board.outstanding() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (board.mismatches == 0 && board.outstanding() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
